>>> src/dcu_pkg.sv
`timescale 1ns / 1ps
// dcu_pkg: shared constants, tables, types and state encodings of the divisor count unit
package dcu_pkg;

    // field widths
    localparam int VALUE_W = 20;
    localparam int COUNT_W = 8;

    // flag memory covers 0 .. VALUE_LIMIT-1
    localparam int VALUE_LIMIT = 1048576;
    localparam int FLAG_AW = (VALUE_LIMIT > 2) ? $clog2(VALUE_LIMIT) : 1;
    localparam int FLAG_W = 2;
    localparam int FLAG_PRIME_BIT = 0;
    localparam int FLAG_SQUARE_BIT = 1;

    // compare width that holds both a value and the limit
    localparam int LIMIT_W = $clog2(VALUE_LIMIT + 1);
    localparam int CMP_W = (VALUE_W > LIMIT_W) ? VALUE_W : LIMIT_W;
    localparam logic [CMP_W-1:0] LIMIT_CMP = CMP_W'(VALUE_LIMIT);

    // sieve square and stride index width
    localparam int SQ_W = FLAG_AW + 2;

    // smallest i with i*i*i >= VALUE_LIMIT
    function automatic int cube_bound();
        int i;
        i = 1;
        while (i * i * i < VALUE_LIMIT)
            i++;
        return i;
    endfunction

    // smallest i with i*i >= VALUE_LIMIT
    function automatic int root_bound();
        int i;
        i = 1;
        while (i * i < VALUE_LIMIT)
            i++;
        return i;
    endfunction

    localparam int CUBE_BOUND = cube_bound();
    localparam int ROOT_BOUND = root_bound();
    localparam int ROOT_W = $clog2(ROOT_BOUND + 1);
    localparam int PW = (CUBE_BOUND > 2) ? $clog2(CUBE_BOUND) : 1;

    // number of primes below the cube bound
    function automatic int count_small_primes();
        int n;
        logic composite [CUBE_BOUND];
        n = 0;
        for (int i = 0; i < CUBE_BOUND; i++)
            composite[i] = 1'b0;
        for (int i = 2; i < CUBE_BOUND; i++) begin
            if (!composite[i]) begin
                n++;
                for (int j = i * i; j < CUBE_BOUND; j += i)
                    composite[j] = 1'b1;
            end
        end
        return n;
    endfunction

    localparam int SMALL_PRIME_COUNT = count_small_primes();
    localparam int SP_TAB = (SMALL_PRIME_COUNT > 0) ? SMALL_PRIME_COUNT : 1;
    localparam int SP_AW = (SP_TAB > 1) ? $clog2(SP_TAB) : 1;
    localparam int SP_IW = $clog2(SP_TAB + 1);

    // exponent counter and divider step counter
    localparam int E_W = $clog2(VALUE_W + 1);
    localparam int DIV_CW = $clog2(VALUE_W);

    typedef logic [PW-1:0] prime_table_t [SP_TAB];
    typedef logic [CMP_W-1:0] cube_table_t [SP_TAB];

    function automatic prime_table_t build_primes();
        prime_table_t t;
        int n;
        logic composite [CUBE_BOUND];
        n = 0;
        for (int k = 0; k < SP_TAB; k++)
            t[k] = '0;
        for (int i = 0; i < CUBE_BOUND; i++)
            composite[i] = 1'b0;
        for (int i = 2; i < CUBE_BOUND; i++) begin
            if (!composite[i]) begin
                t[n] = PW'(i);
                n++;
                for (int j = i * i; j < CUBE_BOUND; j += i)
                    composite[j] = 1'b1;
            end
        end
        return t;
    endfunction

    localparam prime_table_t SMALL_PRIMES = build_primes();

    function automatic cube_table_t build_cubes();
        cube_table_t t;
        int p;
        for (int k = 0; k < SP_TAB; k++) begin
            p = int'(SMALL_PRIMES[k]);
            t[k] = CMP_W'(p * p * p);
        end
        return t;
    endfunction

    localparam cube_table_t SMALL_CUBES = build_cubes();

    // one port of the flag memory
    typedef struct packed {
        logic               wr_en;
        logic [FLAG_AW-1:0] wr_addr;
        logic [FLAG_W-1:0]  wr_data;
        logic               rd_en;
        logic [FLAG_AW-1:0] rd_addr;
    } ram_port_t;

    // trial division request and response
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [PW-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic               exact;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_FILL,
        S_READ,
        S_CHECK,
        S_CROSS,
        S_DONE
    } sieve_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_PRIME,
        C_DIV,
        C_LOOK,
        C_CLASS,
        C_FINISH
    } core_state_t;

endpackage

>>> src/dcu_value_if.sv
`timescale 1ns / 1ps
// dcu_value_if: input channel carrying one value per beat
interface dcu_value_if;
    import dcu_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

>>> src/dcu_count_if.sv
`timescale 1ns / 1ps
// dcu_count_if: output channel carrying one divisor count per beat
interface dcu_count_if;
    import dcu_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] divisor_count;

    modport source (output valid, output divisor_count, input ready);
    modport sink (input valid, input divisor_count, output ready);
endinterface

>>> src/dcu_ram.sv
`timescale 1ns / 1ps
// dcu_ram: generic simple dual port ram, one write and one registered read
module dcu_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/dcu_sieve.sv
`timescale 1ns / 1ps
// dcu_sieve: builds the prime and prime-square flags in the flag memory after reset
module dcu_sieve (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [dcu_pkg::FLAG_W-1:0] rd_data,
    output dcu_pkg::ram_port_t         port,
    output logic                       done
);
    import dcu_pkg::*;

    localparam logic [SQ_W-1:0] SQ_LIMIT = SQ_W'(VALUE_LIMIT);
    localparam logic [FLAG_AW-1:0] LAST_ADDR = FLAG_AW'(VALUE_LIMIT - 1);

    sieve_state_t       state_reg, state_next;
    logic [FLAG_AW-1:0] fill_reg, fill_next;
    logic [ROOT_W-1:0]  i_reg, i_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [SQ_W-1:0]    j_reg, j_next;

    logic [SQ_W-1:0]    sq_adv;
    logic               adv_done;
    logic               is_prime;
    logic               cross_more;

    // (i+1)^2 = i^2 + 2i + 1
    assign sq_adv = sq_reg + SQ_W'({i_reg, 1'b1});
    assign adv_done = (sq_adv >= SQ_LIMIT);
    assign is_prime = rd_data[FLAG_PRIME_BIT];
    assign cross_more = (j_reg < SQ_LIMIT);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_FILL:
            begin
                if (fill_reg == LAST_ADDR)
                begin
                    state_next = (sq_reg >= SQ_LIMIT) ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (is_prime)
                begin
                    state_next = S_CROSS;
                end
                else
                begin
                    state_next = adv_done ? S_DONE : S_READ;
                end
            end
            S_CROSS:
            begin
                if (!cross_more)
                begin
                    state_next = adv_done ? S_DONE : S_READ;
                end
            end
            S_DONE:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    // memory port and counters
    always_comb
    begin
        port = '0;
        fill_next = fill_reg;
        i_next = i_reg;
        sq_next = sq_reg;
        j_next = j_reg;
        done = 1'b0;
        case (state_reg)
            S_FILL:
            begin
                port.wr_en = 1'b1;
                port.wr_addr = fill_reg;
                port.wr_data[FLAG_PRIME_BIT] = (fill_reg > FLAG_AW'(1));
                fill_next = fill_reg + FLAG_AW'(1);
            end
            S_READ:
            begin
                port.rd_en = 1'b1;
                port.rd_addr = FLAG_AW'(i_reg);
            end
            S_CHECK:
            begin
                if (is_prime)
                begin
                    // i*i is the only multiple of i that is a prime square
                    port.wr_en = 1'b1;
                    port.wr_addr = FLAG_AW'(sq_reg);
                    port.wr_data[FLAG_SQUARE_BIT] = 1'b1;
                    j_next = sq_reg + SQ_W'(i_reg);
                end
                else
                begin
                    i_next = i_reg + ROOT_W'(1);
                    sq_next = sq_adv;
                end
            end
            S_CROSS:
            begin
                if (cross_more)
                begin
                    port.wr_en = 1'b1;
                    port.wr_addr = FLAG_AW'(j_reg);
                    j_next = j_reg + SQ_W'(i_reg);
                end
                else
                begin
                    i_next = i_reg + ROOT_W'(1);
                    sq_next = sq_adv;
                end
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            fill_reg <= '0;
            i_reg <= ROOT_W'(2);
            sq_reg <= SQ_W'(4);
            j_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            i_reg <= i_next;
            sq_reg <= sq_next;
            j_reg <= j_next;
        end
    end

endmodule

>>> src/dcu_divider.sv
`timescale 1ns / 1ps
// dcu_divider: bit-serial restoring divider for trial division by a small prime
module dcu_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  dcu_pkg::div_req_t req,
    output dcu_pkg::div_rsp_t rsp
);
    import dcu_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic [PW-1:0]     part_reg, part_next;
    logic [PW-1:0]     dsr_reg, dsr_next;

    logic [PW:0]       trial;
    logic [PW:0]       diff;
    logic              fits;

    assign trial = {part_reg, quo_reg[VALUE_W-1]};
    assign diff = trial - {1'b0, dsr_reg};
    assign fits = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        part_next = part_reg;
        dsr_next = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            quo_next = req.dividend;
            part_next = '0;
            dsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            quo_next = {quo_reg[VALUE_W-2:0], fits};
            part_next = fits ? diff[PW-1:0] : trial[PW-1:0];
            cnt_next = cnt_reg + DIV_CW'(1);
            if (cnt_reg == DIV_CW'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        part_reg <= part_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;
    assign rsp.exact = (part_reg == '0);

endmodule

>>> src/dcu_core.sv
`timescale 1ns / 1ps
// dcu_core: per-value sequencer, small prime trial division and final flag lookup
module dcu_core (
    input  logic                       clk,
    input  logic                       rst_n,
    dcu_value_if.sink                  operand,
    dcu_count_if.source                result,
    input  logic                       sieve_done,
    input  logic [dcu_pkg::FLAG_W-1:0] flag_data,
    output dcu_pkg::ram_port_t         flag_port,
    output dcu_pkg::div_req_t          div_req,
    input  dcu_pkg::div_rsp_t          div_rsp
);
    import dcu_pkg::*;

    localparam int MUL_W = COUNT_W + E_W;
    localparam int FIN_W = COUNT_W + 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    core_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SP_IW-1:0]   k_reg, k_next;
    logic [E_W-1:0]     e_reg, e_next;
    logic               res_valid_reg, res_valid_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;

    logic               in_ready;
    logic               accept;
    logic               trivial;
    logic [PW-1:0]      p_cur;
    logic [CMP_W-1:0]   cube_cur;
    logic               primes_over;
    logic               out_free;
    logic [MUL_W-1:0]   mul_prod;
    logic [COUNT_W-1:0] mul_sat;
    logic [2:0]         factor;
    logic [FIN_W-1:0]   fin_prod;
    logic [COUNT_W-1:0] fin_sat;

    assign in_ready = (state_reg == C_IDLE) && sieve_done;
    assign operand.ready = in_ready;
    assign accept = operand.valid && in_ready;

    // zero and out-of-range values count as zero without any search
    assign trivial = (operand.value == '0) || (CMP_W'(operand.value) >= LIMIT_CMP);

    assign p_cur = SMALL_PRIMES[k_reg[SP_AW-1:0]];
    assign cube_cur = SMALL_CUBES[k_reg[SP_AW-1:0]];
    assign primes_over = (k_reg == SP_IW'(SMALL_PRIME_COUNT)) || (cube_cur > CMP_W'(rem_reg));

    assign out_free = !res_valid_reg || result.ready;

    // count times (exponent + 1), saturated
    assign mul_prod = MUL_W'(count_reg) * MUL_W'(E_W'(e_reg + E_W'(1)));
    assign mul_sat = (mul_prod > MUL_W'(COUNT_MAX)) ? COUNT_MAX : mul_prod[COUNT_W-1:0];

    // leftover class: prime, prime square, two distinct primes or one
    always_comb
    begin
        if (flag_data[FLAG_PRIME_BIT])
        begin
            factor = 3'd2;
        end
        else if (flag_data[FLAG_SQUARE_BIT])
        begin
            factor = 3'd3;
        end
        else if (rem_reg != VALUE_W'(1))
        begin
            factor = 3'd4;
        end
        else
        begin
            factor = 3'd1;
        end
    end

    assign fin_prod = FIN_W'(count_reg) * FIN_W'(factor);
    assign fin_sat = (fin_prod > FIN_W'(COUNT_MAX)) ? COUNT_MAX : fin_prod[COUNT_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    state_next = trivial ? C_FINISH : C_PRIME;
                end
            end
            C_PRIME:
            begin
                state_next = primes_over ? C_LOOK : C_DIV;
            end
            C_DIV:
            begin
                if (div_rsp.done && !div_rsp.exact)
                begin
                    state_next = C_PRIME;
                end
            end
            C_LOOK:
            begin
                state_next = C_CLASS;
            end
            C_CLASS:
            begin
                state_next = C_FINISH;
            end
            C_FINISH:
            begin
                if (out_free)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rem_next = rem_reg;
        count_next = count_reg;
        k_next = k_reg;
        e_next = e_reg;
        res_count_next = res_count_reg;
        res_valid_next = res_valid_reg && !result.ready;
        div_req = '0;
        div_req.divisor = p_cur;
        flag_port = '0;
        case (state_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    rem_next = operand.value;
                    count_next = trivial ? COUNT_W'(0) : COUNT_W'(1);
                    k_next = '0;
                    e_next = '0;
                end
            end
            C_PRIME:
            begin
                if (!primes_over)
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = rem_reg;
                end
            end
            C_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.exact)
                    begin
                        // divisible again: keep dividing by the same prime
                        rem_next = div_rsp.quotient;
                        e_next = e_reg + E_W'(1);
                        div_req.start = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                    end
                    else
                    begin
                        count_next = mul_sat;
                        e_next = '0;
                        k_next = k_reg + SP_IW'(1);
                    end
                end
            end
            C_LOOK:
            begin
                flag_port.rd_en = 1'b1;
                flag_port.rd_addr = FLAG_AW'(rem_reg);
            end
            C_CLASS:
            begin
                count_next = fin_sat;
            end
            C_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_count_next = count_reg;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            k_reg <= '0;
            e_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            e_reg <= e_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        count_reg <= count_next;
        res_count_reg <= res_count_next;
    end

    assign result.valid = res_valid_reg;
    assign result.divisor_count = res_count_reg;

endmodule

>>> src/divisor_count_unit.sv
`timescale 1ns / 1ps
// divisor_count_unit: top level of the divisor count unit
//
//  channel   dir  payload                  beat
//  operand   in   value [19:0] unsigned    one value whose divisors are counted
//  result    out  divisor_count [7:0]      number of divisors, 0 for value 0
//
//  after reset a sieve sequencer fills the flag memory: one write per entry to
//  preset it, then one write per crossed-off multiple, with operand.ready low
//  throughout; per nonzero value, up to 26 small primes are tried, one serial
//  division per prime tried and one more per prime factor divided out, then the
//  leftover is classed by one flag lookup, and the core returns to idle before
//  the next value is taken; one value is worked on at a time; the result
//  register lets the next value enter while a finished count waits on a
//  stalled result channel
module divisor_count_unit (
    input  logic        clk,
    input  logic        rst_n,
    dcu_value_if.sink   operand,
    dcu_count_if.source result
);
    import dcu_pkg::*;

    ram_port_t          sieve_port;
    ram_port_t          core_port;
    ram_port_t          flag_port;
    logic [FLAG_W-1:0]  flag_data;
    logic               sieve_done;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // the sieve owns the flag memory until it is built, the core after that
    assign flag_port = sieve_done ? core_port : sieve_port;

    // flag memory: bit 0 prime, bit 1 square of a prime
    dcu_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (VALUE_LIMIT)
    ) u_flag_ram (
        .clk     (clk),
        .wr_en   (flag_port.wr_en),
        .wr_addr (flag_port.wr_addr),
        .wr_data (flag_port.wr_data),
        .rd_en   (flag_port.rd_en),
        .rd_addr (flag_port.rd_addr),
        .rd_data (flag_data)
    );

    dcu_sieve u_sieve (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_data (flag_data),
        .port    (sieve_port),
        .done    (sieve_done)
    );

    dcu_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dcu_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .operand    (operand),
        .result     (result),
        .sieve_done (sieve_done),
        .flag_data  (flag_data),
        .flag_port  (core_port),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

endmodule
